FILE: design/kfd_pkg.sv
// KISS frame decoder package: byte codes, verdict codes, result word and frame state types.
// No dependencies.
`default_nettype none

package kfd_pkg;

  localparam int unsigned MaxFrame = 4096;
  localparam int unsigned LenW     = 13;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = 2;
  localparam int unsigned QCountW  = 3;

  localparam logic [7:0] ChFend  = 8'hC0;
  localparam logic [7:0] ChFesc  = 8'hDB;
  localparam logic [7:0] ChTfend = 8'hDC;
  localparam logic [7:0] ChTfesc = 8'hDD;
  localparam logic [3:0] CmdPoll = 4'hE;
  localparam logic [3:0] CmdData = 4'h0;

  typedef enum logic [2:0] {
    VERD_DATA_OK    = 3'd0,
    VERD_NONDATA_OK = 3'd1,
    VERD_ESC_ERR    = 3'd2,
    VERD_POLL       = 3'd3,
    VERD_CSUM_BAD   = 3'd4,
    VERD_OVERSIZE   = 3'd5,
    VERD_EMPTY      = 3'd6
  } kfd_verdict_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        data_byte;
    kfd_verdict_t      verdict;
    logic [3:0]        port;
    logic [3:0]        command;
    logic [LenW-1:0]   length;
    logic              stray;
    logic              last;
  } kfd_result_t;

  typedef struct packed {
    logic              esc;
    logic [7:0]        csum;
    logic [LenW-1:0]   count;
    logic [7:0]        held;
    logic              held_vld;
    logic [7:0]        ctrl;
    logic              csum_frame;
    logic              ovf;
    logic              stray;
  } kfd_frame_t;

endpackage

`default_nettype wire

FILE: design/kfd_decode.sv
// KISS unescape, one-byte hold and frame-end verdict; produces up to two result words per byte.
// Depends on kfd_pkg.
`default_nettype none

module kfd_decode (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic [7:0]          line_byte,
  input  wire logic                csum_en,
  output kfd_pkg::kfd_result_t     res0,
  output kfd_pkg::kfd_result_t     res1,
  output logic [1:0]               res_count
);
  import kfd_pkg::*;

  kfd_frame_t st;
  kfd_frame_t st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step) begin
      st <= st_next;
    end
  end

  always_comb begin
    logic [7:0]      b;
    logic [3:0]      cmd;
    kfd_verdict_t    verd;
    logic [LenW-1:0] len;
    kfd_result_t     fe;
    kfd_result_t     dr;

    st_next   = st;
    res0      = '0;
    res1      = '0;
    res_count = 2'd0;
    b         = line_byte;
    cmd       = st.ctrl[3:0];
    verd      = VERD_DATA_OK;
    len       = '0;
    fe        = '0;
    dr        = '0;

    if (st.esc) begin
      verd = VERD_ESC_ERR;
    end else if (st.ovf) begin
      verd = VERD_OVERSIZE;
    end else if (cmd != CmdData) begin
      if (cmd == CmdPoll) begin
        verd = VERD_POLL;
      end else begin
        verd = VERD_NONDATA_OK;
        len  = st.count;
      end
    end else if (st.csum_frame) begin
      if (st.csum != 8'd0) begin
        verd = VERD_CSUM_BAD;
      end else if (st.count == LenW'(1)) begin
        verd = VERD_EMPTY;
      end else begin
        len = st.count - LenW'(1);
      end
    end else begin
      len = st.count;
    end

    fe.kind    = 1'b1;
    fe.verdict = verd;
    fe.port    = st.ctrl[7:4];
    fe.command = cmd;
    fe.length  = len;
    fe.stray   = st.stray;
    fe.last    = 1'b1;

    dr.data_byte = st.held;
    dr.last      = 1'b1;

    if (line_byte == ChFend) begin
      st_next = '0;
      if (st.count != '0) begin
        if (st.held_vld && !st.csum_frame) begin
          res0      = dr;
          res0.last = 1'b0;
          res1      = fe;
          res_count = 2'd2;
        end else begin
          res0      = fe;
          res_count = 2'd1;
        end
      end
    end else if (line_byte == ChFesc) begin
      st_next.esc = 1'b1;
    end else begin
      st_next.esc = 1'b0;
      if (st.esc) begin
        if (line_byte == ChTfend) begin
          b = ChFend;
        end else if (line_byte == ChTfesc) begin
          b = ChFesc;
        end else begin
          st_next.stray = 1'b1;
        end
      end
      if (st.count >= LenW'(MaxFrame)) begin
        st_next.ovf = 1'b1;
      end else begin
        if (st.count == '0) begin
          st_next.ctrl       = b;
          st_next.csum_frame = csum_en && (b[3:0] == CmdData);
        end
        st_next.csum = st.csum ^ b;
        if (st.held_vld) begin
          res0      = dr;
          res_count = 2'd1;
        end
        st_next.held     = b;
        st_next.held_vld = 1'b1;
        st_next.count    = st.count + LenW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/kfd_result_fifo.sv
// Result queue: takes up to two result words a cycle, hands out one.
// Depends on kfd_pkg.
`default_nettype none

module kfd_result_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [1:0]          push_count,
  input  wire kfd_pkg::kfd_result_t push0,
  input  wire kfd_pkg::kfd_result_t push1,
  input  wire logic                pop,
  output logic                     not_empty,
  output logic                     room,
  output kfd_pkg::kfd_result_t     head
);
  import kfd_pkg::*;

  kfd_result_t        mem [QDepth];
  logic [QPtrW-1:0]   wr_ptr;
  logic [QPtrW-1:0]   rd_ptr;
  logic [QCountW-1:0] count;
  logic [QCountW-1:0] count_next;
  logic               do_pop;

  assign not_empty = (count != '0);
  assign room      = (count <= QCountW'(QDepth - 2));
  assign head      = mem[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_comb begin
    count_next = count + QCountW'(push_count) - QCountW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr + QPtrW'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPtrW'(push_count);
      rd_ptr <= rd_ptr + QPtrW'(do_pop);
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/kiss_frame_decoder.sv
// KISS frame decoder top level: input register, decoder, result queue, config register.
// Depends on kfd_pkg, kfd_decode, kfd_result_fifo.
// Each accepted byte goes via the input register and the decoder into the result queue.
// Throughput: one line byte per cycle while the queue has room; a frame end that releases
// a held byte gives two words, both pushed into the four-word queue and popped one at a time.
// Reset clears the frame state, the queue and checksum_enable.
`default_nettype none

module kiss_frame_decoder (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             rx_byte,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   checksum_enable,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        kind,
  output logic [7:0]                  data_byte,
  output logic [2:0]                  verdict,
  output logic [3:0]                  frame_port,
  output logic [3:0]                  frame_command,
  output logic [kfd_pkg::LenW-1:0]    frame_length,
  output logic                        stray_escape,
  output logic                        last
);
  import kfd_pkg::*;

  logic        csum_en;
  logic        in_full;
  logic [7:0]  in_byte;
  logic        room;
  logic        step;
  kfd_result_t res0;
  kfd_result_t res1;
  logic [1:0]  res_count;
  logic [1:0]  push_count;
  kfd_result_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      csum_en <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      csum_en <= checksum_enable;
    end
  end

  assign step     = in_full && room;
  assign in_stall = in_full && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_byte <= rx_byte;
    end
  end

  kfd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .line_byte (in_byte),
    .csum_en   (csum_en),
    .res0      (res0),
    .res1      (res1),
    .res_count (res_count)
  );

  assign push_count = step ? res_count : 2'd0;

  kfd_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (res0),
    .push1      (res1),
    .pop        (!out_stall),
    .not_empty  (out_valid),
    .room       (room),
    .head       (head)
  );

  assign kind          = head.kind;
  assign data_byte     = head.data_byte;
  assign verdict       = head.verdict;
  assign frame_port    = head.port;
  assign frame_command = head.command;
  assign frame_length  = head.length;
  assign stray_escape  = head.stray;
  assign last          = head.last;

endmodule

`default_nettype wire
